/* src/assert_macros.svh */
// Assertion helpers for the allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

/* src/bfra_pkg.sv */
package bfra_pkg;

	localparam int unsigned PAGES_W = 21;
	localparam int unsigned STAMP_W = 32;
	localparam int unsigned IO_ADDR_W = 32;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_ALLOC  = 2'd1,
		FN_FREE   = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_NO_FIT    = 2'd2,
		ST_EXHAUSTED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_WB1,
		S_WB2
	} state_t;

	typedef struct packed {
		logic clear;
		logic eval;
	} scan_ctrl_t;

	typedef struct packed {
		logic best_ok;
		logic empty_ok;
		logic match_ok;
	} scan_res_t;

endpackage

/* src/bfra_ram.sv */
module bfra_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* src/bfra_scan.sv */
module bfra_scan #(
	parameter int unsigned ENTRIES = 64,
	parameter int unsigned PAGE_SHIFT = 12,
	parameter int unsigned ADDR_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bfra_pkg::scan_ctrl_t                   ctrl,
	input  logic [$clog2(ENTRIES)-1:0]             e_idx,
	input  logic                                   e_valid,
	input  logic                                   e_free,
	input  logic [ADDR_BITS-PAGE_SHIFT-1:0]        e_base,
	input  logic [((ADDR_BITS-PAGE_SHIFT > 21) ? ADDR_BITS-PAGE_SHIFT : 21)-1:0] e_count,
	input  logic [bfra_pkg::STAMP_W-1:0]           e_stamp,
	input  logic [bfra_pkg::PAGES_W-1:0]           pages,
	input  logic [ADDR_BITS-1:0]                   addr,
	input  logic [bfra_pkg::STAMP_W-1:0]           stamp_now,
	output bfra_pkg::scan_res_t                    res,
	output logic [$clog2(ENTRIES)-1:0]             best_idx,
	output logic [ADDR_BITS-PAGE_SHIFT-1:0]        best_base,
	output logic [((ADDR_BITS-PAGE_SHIFT > 21) ? ADDR_BITS-PAGE_SHIFT : 21)-1:0] best_count,
	output logic [$clog2(ENTRIES)-1:0]             empty_idx,
	output logic [$clog2(ENTRIES)-1:0]             match_idx
);
	import bfra_pkg::*;

	localparam int unsigned IDX_W = $clog2(ENTRIES);
	localparam int unsigned PB = ADDR_BITS - PAGE_SHIFT;
	localparam int unsigned CNT_W = (PB > PAGES_W) ? PB : PAGES_W;
	localparam int unsigned SPAN_W = CNT_W + PAGE_SHIFT;
	localparam int unsigned CMP_W = (SPAN_W > ADDR_BITS) ? SPAN_W : ADDR_BITS;

	logic             best_ok_q, empty_ok_q, match_ok_q;
	logic [IDX_W-1:0] best_idx_q, empty_idx_q, match_idx_q;
	logic [PB-1:0]    best_base_q;
	logic [CNT_W-1:0] best_cnt_q;
	logic [STAMP_W-1:0] best_age_q;

	logic [STAMP_W-1:0]   age;
	logic                 fit, better, hit;
	logic [ADDR_BITS-1:0] base_a, diff;
	logic [SPAN_W-1:0]    span;

	// score the entry under evaluation
	always_comb begin
		age = stamp_now - e_stamp;
		fit = e_valid && e_free && (e_count >= CNT_W'(pages));
		better = !best_ok_q || (e_count < best_cnt_q)
			|| ((e_count == best_cnt_q) && (age < best_age_q));
		base_a = {e_base, {PAGE_SHIFT{1'b0}}};
		span = {e_count, {PAGE_SHIFT{1'b0}}};
		diff = addr - base_a;
		hit = e_valid && ((addr == base_a)
			|| ((addr > base_a) && (CMP_W'(diff) < CMP_W'(span))));
	end

	// track found flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_ok_q <= 1'b0;
			empty_ok_q <= 1'b0;
			match_ok_q <= 1'b0;
		end else if (ctrl.clear) begin
			best_ok_q <= 1'b0;
			empty_ok_q <= 1'b0;
			match_ok_q <= 1'b0;
		end else if (ctrl.eval) begin
			if (fit && better) best_ok_q <= 1'b1;
			if (!e_valid) empty_ok_q <= 1'b1;
			if (hit) match_ok_q <= 1'b1;
		end
	end

	// hold the chosen entries
	always_ff @(posedge clk) begin
		if (ctrl.eval) begin
			if (fit && better) begin
				best_idx_q <= e_idx;
				best_base_q <= e_base;
				best_cnt_q <= e_count;
				best_age_q <= age;
			end
			if (!e_valid && !empty_ok_q) empty_idx_q <= e_idx;
			if (hit && !match_ok_q) match_idx_q <= e_idx;
		end
	end

	assign res = '{best_ok: best_ok_q, empty_ok: empty_ok_q, match_ok: match_ok_q};
	assign best_idx = best_idx_q;
	assign best_base = best_base_q;
	assign best_count = best_cnt_q;
	assign empty_idx = empty_idx_q;
	assign match_idx = match_idx_q;
endmodule

/* src/best_fit_range_allocator.sv */
// A new transaction is accepted only once the previous one is back in idle;
// a single scan walks the table one entry per cycle through the shared compare unit,
// then the write-back states S_WB1 and S_WB2 follow.
// Reset: asynchronous active-low arst_n clears the table valid and free flags,
// the stamp counter and the sequencer. The receiver cannot stall results.
`include "assert_macros.svh"

module best_fit_range_allocator #(
	parameter int unsigned ENTRIES = 64,
	parameter int unsigned PAGE_SHIFT = 12,
	parameter int unsigned ADDR_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      func,
	input  logic [bfra_pkg::IO_ADDR_W-1:0]  addr,
	input  logic [bfra_pkg::IO_ADDR_W-1:0]  end_addr,
	input  logic [bfra_pkg::PAGES_W-1:0]    pages,
	output logic                            done,
	output logic [1:0]                      status,
	output logic [bfra_pkg::IO_ADDR_W-1:0]  addr_out
);
	import bfra_pkg::*;

	localparam int unsigned IDX_W = $clog2(ENTRIES);
	localparam int unsigned PB = ADDR_BITS - PAGE_SHIFT;
	localparam int unsigned CNT_W = (PB > PAGES_W) ? PB : PAGES_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	state_t state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic             eval_s1, valid_s1, free_s1;
	logic [IDX_W-1:0] idx_s1;
	func_t            func_q;
	logic [ADDR_BITS-1:0] addr_q, end_q;
	logic [PAGES_W-1:0]   pages_q;
	logic [STAMP_W-1:0]   stamp_q;
	logic [ENTRIES-1:0]   valid_q, free_q;
	logic             done_q;
	status_t          status_q;
	logic [IO_ADDR_W-1:0] addr_out_q;

	logic [PB-1:0]      base_rd;
	logic [CNT_W-1:0]   cnt_rd;
	logic [STAMP_W-1:0] stamp_rd;

	scan_ctrl_t       sctl;
	scan_res_t        sres;
	logic [IDX_W-1:0] best_idx, empty_idx, match_idx;
	logic [PB-1:0]    best_base;
	logic [CNT_W-1:0] best_count;

	logic             accept, split;
	logic             base_we, cnt_we, stamp_we, set_vf, clr_f;
	logic [IDX_W-1:0] base_wa, cnt_wa, stamp_wa, flag_idx;
	logic [PB-1:0]    base_wd;
	logic [CNT_W-1:0] cnt_wd;
	logic [ADDR_BITS-1:0] span_a;
	status_t          status_d;
	logic [IO_ADDR_W-1:0] addr_out_d;

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign split = (best_count != CNT_W'(pages_q));
	assign span_a = end_q - addr_q;

	// range table storage
	bfra_ram #(.WIDTH(PB), .DEPTH(ENTRIES)) u_base (
		.clk(clk), .we(base_we), .waddr(base_wa), .wdata(base_wd),
		.raddr(idx_q), .rdata(base_rd)
	);
	bfra_ram #(.WIDTH(CNT_W), .DEPTH(ENTRIES)) u_count (
		.clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd),
		.raddr(idx_q), .rdata(cnt_rd)
	);
	bfra_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp (
		.clk(clk), .we(stamp_we), .waddr(stamp_wa), .wdata(stamp_q),
		.raddr(idx_q), .rdata(stamp_rd)
	);

	// shared compare unit
	assign sctl = '{clear: accept, eval: eval_s1};
	bfra_scan #(.ENTRIES(ENTRIES), .PAGE_SHIFT(PAGE_SHIFT), .ADDR_BITS(ADDR_BITS)) u_scan (
		.clk(clk), .arst_n(arst_n), .ctrl(sctl),
		.e_idx(idx_s1), .e_valid(valid_s1), .e_free(free_s1),
		.e_base(base_rd), .e_count(cnt_rd), .e_stamp(stamp_rd),
		.pages(pages_q), .addr(addr_q), .stamp_now(stamp_q),
		.res(sres), .best_idx(best_idx), .best_base(best_base), .best_count(best_count),
		.empty_idx(empty_idx), .match_idx(match_idx)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) state_d = S_SCAN;
			S_SCAN: if (idx_q == LAST_IDX) state_d = S_LAST;
			S_LAST: state_d = S_WB1;
			S_WB1:  state_d = S_WB2;
			S_WB2:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// write-back actions and result
	always_comb begin
		base_we = 1'b0;
		cnt_we = 1'b0;
		stamp_we = 1'b0;
		set_vf = 1'b0;
		clr_f = 1'b0;
		base_wa = empty_idx;
		cnt_wa = empty_idx;
		stamp_wa = empty_idx;
		flag_idx = empty_idx;
		base_wd = addr_q[ADDR_BITS-1:PAGE_SHIFT];
		cnt_wd = CNT_W'(span_a[ADDR_BITS-1:PAGE_SHIFT]);
		status_d = ST_NOT_FOUND;
		addr_out_d = '0;
		case (state_q)
			S_WB1: begin
				if (func_q == FN_ALLOC && sres.best_ok) begin
					flag_idx = best_idx;
					if (split && !sres.empty_ok) begin
						// no slot for the remainder: leave the entry free and restamp it as newest
						stamp_we = 1'b1;
						stamp_wa = best_idx;
					end else if (split) begin
						clr_f = 1'b1;
						cnt_we = 1'b1;
						cnt_wa = best_idx;
						cnt_wd = CNT_W'(pages_q);
					end else begin
						clr_f = 1'b1;
					end
				end else if (func_q == FN_FREE && sres.match_ok && !free_q[match_idx]) begin
					flag_idx = match_idx;
					set_vf = 1'b1;
					stamp_we = 1'b1;
					stamp_wa = match_idx;
				end
			end
			S_WB2: begin
				case (func_q)
					FN_INSERT: begin
						status_d = sres.empty_ok ? ST_OK : ST_EXHAUSTED;
						if (sres.empty_ok) begin
							base_we = 1'b1;
							cnt_we = 1'b1;
							stamp_we = 1'b1;
							set_vf = 1'b1;
						end
					end
					FN_ALLOC: begin
						if (!sres.best_ok) begin
							status_d = ST_NO_FIT;
						end else if (split && !sres.empty_ok) begin
							status_d = ST_EXHAUSTED;
						end else begin
							status_d = ST_OK;
							addr_out_d = IO_ADDR_W'({best_base, {PAGE_SHIFT{1'b0}}});
							if (split) begin
								// remainder becomes the newest free entry
								base_we = 1'b1;
								cnt_we = 1'b1;
								stamp_we = 1'b1;
								set_vf = 1'b1;
								base_wd = best_base + PB'(pages_q);
								cnt_wd = CNT_W'(PB'(best_count - CNT_W'(pages_q)));
							end
						end
					end
					FN_FREE: status_d = sres.match_ok ? ST_OK : ST_NOT_FOUND;
					default: status_d = ST_NOT_FOUND;
				endcase
			end
			default: ;
		endcase
	end

	// sequencer, flags and stamp counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			eval_s1 <= 1'b0;
			valid_q <= '0;
			free_q <= '0;
			stamp_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			eval_s1 <= (state_q == S_SCAN);
			if (accept) begin
				idx_q <= '0;
			end else if (state_q == S_SCAN && idx_q != LAST_IDX) begin
				idx_q <= idx_q + 1'b1;
			end
			if (set_vf) begin
				valid_q[flag_idx] <= 1'b1;
				free_q[flag_idx] <= 1'b1;
			end
			if (clr_f) free_q[flag_idx] <= 1'b0;
			if (stamp_we) stamp_q <= stamp_q + 1'b1;
			done_q <= (state_q == S_WB2);
		end
	end

	// capture the transaction and the scan tap
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func_t'(func);
			addr_q <= ADDR_BITS'(addr);
			end_q <= ADDR_BITS'(end_addr);
			pages_q <= pages;
		end
		idx_s1 <= idx_q;
		valid_s1 <= valid_q[idx_q];
		free_s1 <= free_q[idx_q];
		if (state_q == S_WB2) begin
			status_q <= status_d;
			addr_out_q <= addr_out_d;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign addr_out = addr_out_q;

	`ASSERT_CLK(a_done_idle, clk, arst_n, done |-> (state_q == S_IDLE), "done outside idle")
	`ASSERT_CLK(a_done_pulse, clk, arst_n, done |=> !done, "done held two cycles")
	`ASSERT_CLK(a_stamp_step, clk, arst_n,
		(stamp_q != $past(stamp_q)) |-> (stamp_q == $past(stamp_q) + 1'b1), "stamp jump")
endmodule
